// ===== hw/rtl/lfpc_pkg.sv =====
// Shared types and constants for the line follower proportional controller.
package lfpc_pkg;

    localparam int N_IN      = 4;   // sensors with a sample port
    localparam int SEL_W     = 2;   // sensor select width
    localparam int SAMP_W    = 10;  // ADC sample width
    localparam int LEVEL_W   = 8;   // internal normalized level width
    localparam int ACC_W     = 18;  // product / remainder width
    localparam int DIV_STEPS = 8;   // quotient bits
    localparam int K_W       = 3;   // divide step index width

    typedef logic [SAMP_W-1:0]  t_samp;
    typedef logic [LEVEL_W-1:0] t_level;

    typedef enum logic [1:0] {
        CMD_CAL_START  = 2'd0,
        CMD_CAL_SAMPLE = 2'd1,
        CMD_RUN        = 2'd2
    } t_cmd;

    localparam logic [1:0] REG_BASE_SPEED = 2'd0;
    localparam logic [1:0] REG_GAIN       = 2'd1;

    localparam logic [7:0] BASE_SPEED_RST = 8'd255;
    localparam logic [7:0] GAIN_RST       = 8'd10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_DIV,
        ST_STORE,
        ST_ERR,
        ST_GAIN,
        ST_DRIVE,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        AR_HOLD,
        AR_MUL,
        AR_DIV
    } t_arith_op;

    typedef struct packed {
        t_arith_op      op;
        logic [K_W-1:0] k;
    } t_arith_ctl;

endpackage

// ===== hw/rtl/lfpc_arith.sv =====
// Shared multiply and restoring divide-step unit.
module lfpc_arith
    import lfpc_pkg::*;
(
    input  logic             i_clk,
    input  t_arith_ctl       i_ctl,
    input  t_samp            i_a,
    input  logic [7:0]       i_b,
    input  t_samp            i_divisor,
    output logic [ACC_W-1:0] o_acc,
    output t_level           o_quot
);

    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] n_acc;
    t_level           r_quot;
    t_level           n_quot;
    logic [ACC_W-1:0] w_dsh;
    logic             w_ge;

    assign w_dsh = {{(ACC_W-SAMP_W){1'b0}}, i_divisor} << i_ctl.k;
    assign w_ge  = (r_acc >= w_dsh);

    always_comb begin
        n_acc  = r_acc;
        n_quot = r_quot;
        case (i_ctl.op)
            AR_MUL: begin
                n_acc  = ACC_W'(i_a * i_b);
                n_quot = '0;
            end
            AR_DIV: begin
                if (w_ge) begin
                    n_acc          = r_acc - w_dsh;
                    n_quot[i_ctl.k] = 1'b1;
                end
            end
            default: begin
                n_acc  = r_acc;
                n_quot = r_quot;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_quot <= n_quot;
    end

    assign o_acc  = r_acc;
    assign o_quot = r_quot;

endmodule

// ===== hw/rtl/lfpc_cal.sv =====
// Per-sensor calibration minimum and maximum registers.
module lfpc_cal
    import lfpc_pkg::*;
#(
    parameter int NUM_ACT = 4
)(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_upd,
    input  logic  i_start,
    input  t_samp i_samp [N_IN],
    output t_samp o_lo   [N_IN],
    output t_samp o_hi   [N_IN]
);

    t_samp r_min [NUM_ACT];
    t_samp r_max [NUM_ACT];

    for (genvar g = 0; g < N_IN; g++) begin : g_sens
        if (g < NUM_ACT) begin : g_act
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_min[g] <= '0;
                    r_max[g] <= '0;
                end else if (i_upd) begin
                    if (i_start) begin
                        r_min[g] <= i_samp[g];
                        r_max[g] <= i_samp[g];
                    end else if (i_samp[g] > r_max[g]) begin
                        r_max[g] <= i_samp[g];
                    end else if (i_samp[g] < r_min[g]) begin
                        r_min[g] <= i_samp[g];
                    end
                end
            end
            assign o_lo[g] = r_min[g];
            assign o_hi[g] = r_max[g];
        end else begin : g_none
            // no storage: zero range reads as level 0
            assign o_lo[g] = '0;
            assign o_hi[g] = '0;
        end
    end

`ifndef NO_ASSERTIONS
    // bounds of the first and last sensor stay ordered from reset on
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min[0] <= r_max[0] && r_min[NUM_ACT-1] <= r_max[NUM_ACT-1])
        else $error("calibration min above max");
`endif

endmodule

// ===== hw/rtl/line_follower_p_controller_unit.sv =====
// Line follower proportional controller, top level.
// A calibration word (start or sample) updates the per-sensor bounds at acceptance
// and its all-zero result goes straight to the done state; the block then takes
// the next word. A run word sweeps the four sensors on the one shared
// multiply/divide unit, each with setup, one multiply by the scale, an 8-step
// restoring divide and store, then steps through error, gain multiply, drive
// saturation and handoff. Results sit in an output register, so a new word is
// accepted while the last result waits.
module line_follower_p_controller_unit
    import lfpc_pkg::*;
#(
    parameter int NUM_SENSORS = 4,
    parameter int SCALE_TOP   = 100
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_command,
    input  logic [9:0]        i_sample_right_center,
    input  logic [9:0]        i_sample_left_center,
    input  logic [9:0]        i_sample_right_outer,
    input  logic [9:0]        i_sample_left_outer,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_left_drive,
    output logic [7:0]        o_right_drive,
    output logic signed [7:0] o_line_error,
    output logic [6:0]        o_level_right_center,
    output logic [6:0]        o_level_left_center,
    output logic [6:0]        o_level_right_outer,
    output logic [6:0]        o_level_left_outer,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data
);

    localparam int NUM_ACT = (NUM_SENSORS < N_IN) ? NUM_SENSORS : N_IN;
    localparam logic [7:0] SCALE_B = 8'(SCALE_TOP);

    t_state            r_state;
    t_state            n_state;
    logic [7:0]        r_base;
    logic [7:0]        r_gain;
    logic [SEL_W-1:0]  r_sel;
    logic [K_W-1:0]    r_k;
    t_samp             r_samp [N_IN];
    t_level            r_lev  [N_IN];
    logic              r_force;
    t_level            r_fval;
    t_samp             r_d;
    t_samp             r_dv;
    logic [7:0]        r_err;
    logic [7:0]        r_res_left;
    logic [7:0]        r_res_right;

    logic              r_out_valid;
    logic [7:0]        r_out_left;
    logic [7:0]        r_out_right;
    logic [7:0]        r_out_err;
    logic [6:0]        r_out_lev [N_IN];

    logic              w_accept;
    logic              w_out_free;
    t_samp             w_in_samp [N_IN];
    t_samp             w_lo [N_IN];
    t_samp             w_hi [N_IN];
    t_samp             w_x;
    t_samp             w_cl;
    t_samp             w_ch;
    t_arith_ctl        w_ctl;
    t_samp             w_a;
    logic [7:0]        w_b;
    logic [ACC_W-1:0]  w_acc;
    t_level            w_quot;
    logic signed [9:0] w_corr;
    logic signed [9:0] w_lsum;
    logic signed [9:0] w_rsum;
    logic [7:0]        w_lsat;
    logic [7:0]        w_rsat;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign w_in_samp[0] = i_sample_right_center;
    assign w_in_samp[1] = i_sample_left_center;
    assign w_in_samp[2] = i_sample_right_outer;
    assign w_in_samp[3] = i_sample_left_outer;

    lfpc_cal #(
        .NUM_ACT (NUM_ACT)
    ) u_cal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (w_accept && (i_command == CMD_CAL_START || i_command == CMD_CAL_SAMPLE)),
        .i_start (i_command == CMD_CAL_START),
        .i_samp  (w_in_samp),
        .o_lo    (w_lo),
        .o_hi    (w_hi)
    );

    lfpc_arith u_arith (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_a       (w_a),
        .i_b       (w_b),
        .i_divisor (r_dv),
        .o_acc     (w_acc),
        .o_quot    (w_quot)
    );

    assign w_x  = r_samp[r_sel];
    assign w_cl = w_lo[r_sel];
    assign w_ch = w_hi[r_sel];

    // correction is the low byte of err * gain, taken as int8
    assign w_corr = {{2{w_acc[7]}}, w_acc[7:0]};
    assign w_lsum = $signed({2'b00, r_base}) + w_corr;
    assign w_rsum = $signed({2'b00, r_base}) - w_corr;
    assign w_lsat = w_lsum[9] ? 8'd0 : (w_lsum[8] ? 8'd255 : w_lsum[7:0]);
    assign w_rsat = w_rsum[9] ? 8'd0 : (w_rsum[8] ? 8'd255 : w_rsum[7:0]);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_command == CMD_RUN) ? ST_SETUP : ST_DONE;
                end
            end
            ST_SETUP: n_state = ST_MUL;
            ST_MUL:   n_state = ST_DIV;
            ST_DIV: begin
                if (r_k == '0) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: n_state = (r_sel == SEL_W'(N_IN-1)) ? ST_ERR : ST_SETUP;
            ST_ERR:   n_state = ST_GAIN;
            ST_GAIN:  n_state = ST_DRIVE;
            ST_DRIVE: n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // shared unit control
    always_comb begin
        w_ctl.op = AR_HOLD;
        w_ctl.k  = r_k;
        w_a      = r_d;
        w_b      = SCALE_B;
        unique case (r_state)
            ST_MUL: w_ctl.op = AR_MUL;
            ST_DIV: w_ctl.op = AR_DIV;
            ST_GAIN: begin
                w_ctl.op = AR_MUL;
                w_a      = {2'b00, r_err};
                w_b      = r_gain;
            end
            default: w_ctl.op = AR_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_base      <= BASE_SPEED_RST;
            r_gain      <= GAIN_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_BASE_SPEED) begin
                    r_base <= i_cfg_data;
                end else if (i_cfg_index == REG_GAIN) begin
                    r_gain <= i_cfg_data;
                end
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_samp      <= w_in_samp;
                    r_sel       <= '0;
                    r_err       <= '0;
                    r_res_left  <= '0;
                    r_res_right <= '0;
                    for (int i = 0; i < N_IN; i++) begin
                        r_lev[i] <= '0;
                    end
                end
            end
            ST_SETUP: begin
                r_force <= (w_ch <= w_cl) || (w_x <= w_cl) || (w_x >= w_ch);
                r_fval  <= ((w_ch > w_cl) && (w_x >= w_ch)) ? SCALE_B : '0;
                r_d     <= w_x - w_cl;
                r_dv    <= w_ch - w_cl;
            end
            ST_MUL:   r_k <= K_W'(DIV_STEPS-1);
            ST_DIV:   r_k <= r_k - 1'b1;
            ST_STORE: begin
                r_lev[r_sel] <= r_force ? r_fval : w_quot;
                r_sel        <= r_sel + 1'b1;
            end
            ST_ERR:   r_err <= r_lev[0] - r_lev[1];
            ST_DRIVE: begin
                r_res_left  <= w_lsat;
                r_res_right <= w_rsat;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    r_out_left  <= r_res_left;
                    r_out_right <= r_res_right;
                    r_out_err   <= r_err;
                    for (int i = 0; i < N_IN; i++) begin
                        r_out_lev[i] <= r_lev[i][6:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid          = r_out_valid;
    assign o_left_drive         = r_out_left;
    assign o_right_drive        = r_out_right;
    assign o_line_error         = $signed(r_out_err);
    assign o_level_right_center = r_out_lev[0];
    assign o_level_left_center  = r_out_lev[1];
    assign o_level_right_outer  = r_out_lev[2];
    assign o_level_left_outer   = r_out_lev[3];

`ifndef NO_ASSERTIONS
    // in-range samples divide to a quotient strictly below full scale
    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STORE && !r_force) |-> (w_quot < SCALE_B))
        else $error("divide quotient out of range");

    a_lev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ERR) |-> (r_lev[0] <= SCALE_B && r_lev[1] <= SCALE_B))
        else $error("level above full scale");

    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_command == CMD_RUN) |=> (r_state == ST_SETUP && r_sel == '0))
        else $error("run word did not start sensor sweep");

    // a finished result is never dropped while the output is stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && i_out_stall) |=> (r_state == ST_DONE))
        else $error("result left done state while output busy");
`endif

endmodule

// ===== verif/lfpc_drive_checker.sv =====
// Checker for the line follower controller: predicts each drive word and compares it.
`timescale 1ns / 1ps

module lfpc_drive_checker
    import lfpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [1:0]        i_command,
    input  t_samp             i_sample_right_center,
    input  t_samp             i_sample_left_center,
    input  t_samp             i_sample_right_outer,
    input  t_samp             i_sample_left_outer,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [7:0]        i_left_drive,
    input  logic [7:0]        i_right_drive,
    input  logic signed [7:0] i_line_error,
    input  logic [6:0]        i_level_right_center,
    input  logic [6:0]        i_level_left_center,
    input  logic [6:0]        i_level_right_outer,
    input  logic [6:0]        i_level_left_outer,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);

    localparam int LEVEL_TOP  = 100;
    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        logic [7:0]       left;
        logic [7:0]       right;
        logic [7:0]       err;
        logic [3:0][6:0]  lev;
    } t_drive_word;

    logic [7:0]  base_speed;
    logic [7:0]  drive_gain;
    logic [9:0]  cal_lo [4];
    logic [9:0]  cal_hi [4];
    t_drive_word drive_words_due [$];
    int          fail_count = 0;
    int          checked = 0;

    assign o_fail_count = fail_count;
    assign o_checked    = checked;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < MAX_PRINTS)
            $display("MISMATCH @%0t: %s got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic logic [6:0] norm_level(input int x, input int lo, input int hi);
        if (hi <= lo || x <= lo)
            return 7'd0;
        if (x >= hi)
            return 7'(LEVEL_TOP);
        return 7'((x - lo) * LEVEL_TOP / (hi - lo));
    endfunction

    function automatic logic [7:0] clamp_drive(input int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return 8'(v);
    endfunction

    // Returns the drive word for one input word; calibration words update the bounds.
    function automatic t_drive_word step_controller(input logic [1:0] cmd,
                                                    input logic [3:0][9:0] samp);
        t_drive_word       w;
        logic signed [7:0] err_s;
        logic signed [7:0] corr;
        w = '0;
        case (cmd)
            CMD_CAL_START: begin
                for (int i = 0; i < 4; i++) begin
                    cal_lo[i] = samp[i];
                    cal_hi[i] = samp[i];
                end
            end
            CMD_CAL_SAMPLE: begin
                for (int i = 0; i < 4; i++) begin
                    if (samp[i] > cal_hi[i])
                        cal_hi[i] = samp[i];
                    else if (samp[i] < cal_lo[i])
                        cal_lo[i] = samp[i];
                end
            end
            CMD_RUN: begin
                for (int i = 0; i < 4; i++)
                    w.lev[i] = norm_level(int'(samp[i]), int'(cal_lo[i]), int'(cal_hi[i]));
                err_s   = 8'(int'(w.lev[0]) - int'(w.lev[1]));
                // product wraps to 8 bits before the drive sums
                corr    = 8'(int'(err_s) * int'(drive_gain));
                w.err   = err_s;
                w.left  = clamp_drive(int'(base_speed) + int'(corr));
                w.right = clamp_drive(int'(base_speed) - int'(corr));
            end
            default: ;
        endcase
        return w;
    endfunction

    always @(posedge i_clk) begin : watch
        t_drive_word want;
        if (!i_rst_n) begin
            base_speed = BASE_SPEED_RST;
            drive_gain = GAIN_RST;
            for (int i = 0; i < 4; i++) begin
                cal_lo[i] = '0;
                cal_hi[i] = '0;
            end
            drive_words_due.delete();
        end else begin
            // results first: a word accepted at this edge cannot leave at the same edge
            if (i_out_valid && !i_out_stall) begin
                checked++;
                if (drive_words_due.size() == 0) begin
                    report_mismatch("unexpected result, words due", 1, 0);
                end else begin
                    want = drive_words_due.pop_front();
                    if (i_left_drive != want.left)
                        report_mismatch("left_drive", int'(i_left_drive), int'(want.left));
                    if (i_right_drive != want.right)
                        report_mismatch("right_drive", int'(i_right_drive),
                                        int'(want.right));
                    if (i_line_error != $signed(want.err))
                        report_mismatch("line_error", int'(i_line_error),
                                        int'($signed(want.err)));
                    if (i_level_right_center != want.lev[0])
                        report_mismatch("level_right_center", int'(i_level_right_center),
                                        int'(want.lev[0]));
                    if (i_level_left_center != want.lev[1])
                        report_mismatch("level_left_center", int'(i_level_left_center),
                                        int'(want.lev[1]));
                    if (i_level_right_outer != want.lev[2])
                        report_mismatch("level_right_outer", int'(i_level_right_outer),
                                        int'(want.lev[2]));
                    if (i_level_left_outer != want.lev[3])
                        report_mismatch("level_left_outer", int'(i_level_left_outer),
                                        int'(want.lev[3]));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_BASE_SPEED: base_speed = i_cfg_data;
                    REG_GAIN:       drive_gain = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                drive_words_due.push_back(step_controller(i_command,
                    {i_sample_left_outer, i_sample_right_outer,
                     i_sample_left_center, i_sample_right_center}));
        end
        o_pending = drive_words_due.size();
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top: clock, reset, stimulus, flow control and verdict for the controller.
`timescale 1ns / 1ps

module tb;
    import lfpc_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         WORD_TARGET  = 1750;
    localparam int         NUM_PHASES   = 8;
    localparam int         LONG_HOLD    = 300;
    localparam int         SETTLE_CYCLES = 8;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [1:0]        i_command;
    t_samp             i_sample_right_center;
    t_samp             i_sample_left_center;
    t_samp             i_sample_right_outer;
    t_samp             i_sample_left_outer;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [7:0]        o_left_drive;
    logic [7:0]        o_right_drive;
    logic signed [7:0] o_line_error;
    logic [6:0]        o_level_right_center;
    logic [6:0]        o_level_left_center;
    logic [6:0]        o_level_right_outer;
    logic [6:0]        o_level_left_outer;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index;
    logic [7:0]        i_cfg_data;

    int fail_count;
    int words_pending;
    int results_checked;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_asked = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int words_sent = 0;
    int run_words = 0;
    int cal_words = 0;
    int unused_words = 0;

    always #5 i_clk = ~i_clk;

    line_follower_p_controller_unit u_top (.*);

    lfpc_drive_checker u_checker (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .i_in_stall            (o_in_stall),
        .i_command             (i_command),
        .i_sample_right_center (i_sample_right_center),
        .i_sample_left_center  (i_sample_left_center),
        .i_sample_right_outer  (i_sample_right_outer),
        .i_sample_left_outer   (i_sample_left_outer),
        .i_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .i_left_drive          (o_left_drive),
        .i_right_drive         (o_right_drive),
        .i_line_error          (o_line_error),
        .i_level_right_center  (o_level_right_center),
        .i_level_left_center   (o_level_left_center),
        .i_level_right_outer   (o_level_right_outer),
        .i_level_left_outer    (o_level_left_outer),
        .i_cfg_valid           (i_cfg_valid),
        .i_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .o_fail_count          (fail_count),
        .o_pending             (words_pending),
        .o_checked             (results_checked)
    );

    // Receiver: random stalls, or a long hold-off when one is asked for.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_seen != hold_asked) begin
            hold_seen   <= hold_asked;
            hold_left   <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end
    end

    initial begin
        #20_000_000;
        $display("TIMEOUT: run did not finish, %0d words due", words_pending);
        $display("status: fail");
        $finish;
    end

    // Valid stays up across back-to-back words; it only drops for an idle gap.
    task automatic send_word(input logic [1:0] cmd, input t_samp rc, input t_samp lc,
                             input t_samp ro, input t_samp lo);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge i_clk);
        end
        i_in_valid            <= 1'b1;
        i_command             <= cmd;
        i_sample_right_center <= rc;
        i_sample_left_center  <= lc;
        i_sample_right_outer  <= ro;
        i_sample_left_outer   <= lo;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        words_sent++;
        case (cmd) inside
            CMD_RUN:                          run_words++;
            [CMD_CAL_START:CMD_CAL_SAMPLE]:   cal_words++;
            default:                          unused_words++;
        endcase
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_samp near(input int centre, input int spread);
        int v;
        v = centre + int'($urandom_range(2 * spread)) - spread;
        if (v < 0)
            v = 0;
        else if (v > 1023)
            v = 1023;
        return t_samp'(v);
    endfunction

    // Calibrate around a random working point, then run with samples near it.
    task automatic send_tracked_run();
        int centre [4];
        int spread [4];
        int n_cal;
        int n_run;
        for (int i = 0; i < 4; i++) begin
            centre[i] = $urandom_range(1023);
            spread[i] = ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom_range(511);
        end
        send_word(CMD_CAL_START, t_samp'(centre[0]), t_samp'(centre[1]),
                  t_samp'(centre[2]), t_samp'(centre[3]));
        n_cal = $urandom_range(6, 1);
        repeat (n_cal)
            send_word(CMD_CAL_SAMPLE, near(centre[0], spread[0]), near(centre[1], spread[1]),
                      near(centre[2], spread[2]), near(centre[3], spread[3]));
        for (int i = 0; i < 4; i++)
            spread[i] = spread[i] + spread[i] / 4 + 2;
        n_run = $urandom_range(16, 4);
        repeat (n_run)
            send_word(CMD_RUN, near(centre[0], spread[0]), near(centre[1], spread[1]),
                      near(centre[2], spread[2]), near(centre[3], spread[3]));
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(4, 1);
        repeat (n)
            send_word(2'($urandom_range(3)), t_samp'($urandom), t_samp'($urandom),
                      t_samp'($urandom), t_samp'($urandom));
    endtask

    task automatic send_directed();
        // zero range everywhere straight after reset
        send_word(CMD_RUN, 10'd0, 10'd1023, 10'd512, 10'd7);
        send_word(CMD_UNUSED, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        send_word(CMD_CAL_START, 10'd512, 10'd512, 10'd512, 10'd512);
        send_word(CMD_CAL_SAMPLE, 10'd0, 10'd0, 10'd1023, 10'd512);
        send_word(CMD_CAL_SAMPLE, 10'd1023, 10'd1023, 10'd0, 10'd512);
        // full-scale error both ways, outer left still has zero range
        send_word(CMD_RUN, 10'd1023, 10'd0, 10'd1023, 10'd512);
        send_word(CMD_RUN, 10'd0, 10'd1023, 10'd0, 10'd0);
        send_word(CMD_RUN, 10'd1, 10'd1022, 10'd511, 10'd513);
        send_word(CMD_RUN, 10'd10, 10'd11, 10'd1000, 10'd1023);
        // unused command must leave the bounds alone
        send_word(CMD_UNUSED, 10'd0, 10'd0, 10'd0, 10'd0);
        send_word(CMD_RUN, 10'd600, 10'd300, 10'd700, 10'd800);
        send_word(CMD_CAL_START, 10'd100, 10'd200, 10'd300, 10'd400);
        send_word(CMD_CAL_SAMPLE, 10'd50, 10'd250, 10'd300, 10'd400);
        send_word(CMD_RUN, 10'd50, 10'd250, 10'd299, 10'd401);
        send_word(CMD_RUN, 10'd75, 10'd225, 10'd0, 10'd1023);
        send_word(CMD_RUN, 10'd49, 10'd251, 10'd300, 10'd400);
        send_word(CMD_RUN, 10'd99, 10'd201, 10'd300, 10'd400);
        send_word(CMD_RUN, 10'd51, 10'd249, 10'd300, 10'd400);
    endtask

    initial begin
        logic [7:0] set_base;
        logic [7:0] set_gain;
        i_rst_n               <= 1'b0;
        i_in_valid            <= 1'b0;
        i_command             <= CMD_CAL_START;
        i_sample_right_center <= '0;
        i_sample_left_center  <= '0;
        i_sample_right_outer  <= '0;
        i_sample_left_outer   <= '0;
        i_cfg_valid           <= 1'b0;
        i_cfg_index           <= REG_BASE_SPEED;
        i_cfg_data            <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                settle();
                case (phase)
                    1:       begin set_base = 8'd0;   set_gain = 8'd0;   end
                    2:       begin set_base = 8'd255; set_gain = 8'd255; end
                    3:       begin set_base = 8'd128; set_gain = 8'd1;   end
                    4:       begin set_base = 8'd0;   set_gain = 8'd255; end
                    5:       begin set_base = 8'd255; set_gain = 8'd0;   end
                    default: begin
                        set_base = 8'($urandom_range(255));
                        set_gain = 8'($urandom_range(255));
                    end
                endcase
                write_reg(REG_BASE_SPEED, set_base);
                write_reg(REG_GAIN, set_gain);
            end
            case (phase % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 56; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 56; end
                default: begin send_idle_pct = 32; stall_pct = 32; end
            endcase
            if (phase == 0)
                send_directed();
            // long receiver hold with a busy sender so the block backs up
            if (phase == 0 || phase == 4)
                hold_asked++;
            while (words_sent < WORD_TARGET * (phase + 1) / NUM_PHASES) begin
                if ($urandom_range(4) != 0)
                    send_tracked_run();
                else
                    send_noise();
            end
        end
        settle();

        $display("covered %0d words: %0d run, %0d calibration, %0d unused command",
                 words_sent, run_words, cal_words, unused_words);
        $display("%0d results checked over %0d gain/speed settings and 4 flow-control modes",
                 results_checked, NUM_PHASES);
        if (fail_count == 0 && words_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
